[rtl/iws_pkg.sv]
// Shared constants, types and helpers of the instance window store.
`default_nettype none

package iws_pkg;

  // Ring size; must be a power of two, at least 2.
  localparam int unsigned RING_SLOTS  = 1024;
  localparam int unsigned SLOT_W      = $clog2(RING_SLOTS);
  localparam int unsigned N_W         = 32;
  localparam int unsigned KIND_W      = 3;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned IDX_W       = 10;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [N_W:0]   SPAN    = (N_W + 1)'(RING_SLOTS);
  localparam logic [N_W-1:0] SPAN_M1 = N_W'(RING_SLOTS - 1);

  localparam logic [KIND_W-1:0] KIND_LOOKUP = 3'd0;
  localparam logic [KIND_W-1:0] KIND_BIRTH  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_WALL   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SNAP   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_COMMIT = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_DEAD        = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_FORGOTTEN   = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_BEHIND_WALL = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_UNREACHABLE = 3'd4;

  typedef enum logic [2:0] {
    OP_LOOKUP,
    OP_BIRTH,
    OP_WALL,
    OP_SNAP,
    OP_COMMIT,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t            op;
    logic [N_W-1:0] n;
  } iws_entry_t;

  typedef struct packed {
    logic full;
    logic clearing;
  } iws_qstat_t;

  typedef struct packed {
    logic           valid;
    logic           committed;
    logic [N_W-1:0] tag;
  } slot_word_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_LK_CHK,
    BK_CM_CHK,
    BK_WK_RD,
    BK_WK_CHK
  } back_state_t;

  function automatic logic [SLOT_W-1:0] slot_of(input logic [N_W-1:0] n);
    return n[SLOT_W-1:0];
  endfunction

  // n + 1, held at the top value
  function automatic logic [N_W-1:0] inc_sat(input logic [N_W-1:0] n);
    return (n == '1) ? n : n + N_W'(1);
  endfunction

endpackage

`default_nettype wire

[rtl/instance_window_store.sv]
// Instance window store: a ring of 1024 instance slots behind window pointers.
//
// Input channel (in_valid/in_ready): kind and instance_number. Kinds are
// lookup, set birth, move wall, move snapshot and commit; one result item is
// returned on the output channel (out_valid/out_ready) for every input item,
// in order.
// Accepted items pass through a two-entry queue to the back part, which owns
// the pointers, the slot store (one read and one write port, registered read)
// and the result register.
// Set birth, move wall, move snapshot, refused lookups and commits before birth
// are answered straight from the idle state; a lookup that reaches its slot
// reads it, then answers from the lookup check state; a commit reads and checks
// its slot, then walks the window slot by slot and answers where the walk
// stops, at the first slot it cannot pass or at the end of the window.
// A lookup's read and write-back finish before the next item is taken.
// After reset the slot store is swept, one slot per cycle, over all 1024 slots;
// in_ready stays low until the sweep ends and every pointer reads zero.
// When the receiver stalls, the result waits in the output register, the
// back part holds its next result, and the queue keeps taking items until
// it is full.
`default_nettype none

module instance_window_store (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [iws_pkg::KIND_W-1:0]    kind,
  input  wire logic [iws_pkg::N_W-1:0]       instance_number,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [iws_pkg::STATUS_W-1:0]       status,
  output logic [iws_pkg::IDX_W-1:0]          slot_index,
  output logic                               fresh_entry,
  output logic                               entry_committed,
  output logic [iws_pkg::N_W-1:0]            lowest_uncommitted,
  output logic [iws_pkg::N_W-1:0]            next_after_touched
);
  import iws_pkg::*;

  iws_qstat_t qstat;
  logic       push;
  iws_entry_t push_entry;
  logic       q_full;
  logic       pop;
  logic       head_valid;
  iws_entry_t head;
  logic       clearing;

  assign qstat.full     = q_full;
  assign qstat.clearing = clearing;

  iws_front u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .kind            (kind),
    .instance_number (instance_number),
    .qstat           (qstat),
    .push            (push),
    .push_entry      (push_entry)
  );

  iws_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  iws_back u_back (
    .clk                (clk),
    .rst                (rst),
    .head_valid         (head_valid),
    .head               (head),
    .pop                (pop),
    .clearing           (clearing),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .status             (status),
    .slot_index         (slot_index),
    .fresh_entry        (fresh_entry),
    .entry_committed    (entry_committed),
    .lowest_uncommitted (lowest_uncommitted),
    .next_after_touched (next_after_touched)
  );

endmodule

`default_nettype wire

[rtl/iws_front.sv]
// Input side: accepts items and classifies them into queue entries.
`default_nettype none

module iws_front (
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [iws_pkg::KIND_W-1:0] kind,
  input  wire logic [iws_pkg::N_W-1:0]  instance_number,
  input  wire iws_pkg::iws_qstat_t      qstat,
  output logic                          push,
  output iws_pkg::iws_entry_t           push_entry
);
  import iws_pkg::*;

  op_t op;

  always_comb begin
    case (kind)
      KIND_LOOKUP: op = OP_LOOKUP;
      KIND_BIRTH:  op = OP_BIRTH;
      KIND_WALL:   op = OP_WALL;
      KIND_SNAP:   op = OP_SNAP;
      KIND_COMMIT: op = OP_COMMIT;
      default:     op = OP_NONE;
    endcase
  end

  // Hold off while the slot store is being swept after reset.
  assign in_ready        = !qstat.full && !qstat.clearing;
  assign push            = in_valid && in_ready;
  assign push_entry.op   = op;
  assign push_entry.n    = instance_number;

endmodule

`default_nettype wire

[rtl/iws_queue.sv]
// Short queue of classified items between the front and back parts.
`default_nettype none

module iws_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire iws_pkg::iws_entry_t push_entry,
  output logic                     full,
  input  wire logic                pop,
  output logic                     head_valid,
  output iws_pkg::iws_entry_t      head
);
  import iws_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  iws_entry_t       entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= advance(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= advance(rd_ptr);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/iws_back.sv]
// Back part: window pointers, slot store, commit walk and the result register.
`default_nettype none

module iws_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         head_valid,
  input  wire iws_pkg::iws_entry_t          head,
  output logic                              pop,
  output logic                              clearing,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [iws_pkg::STATUS_W-1:0]      status,
  output logic [iws_pkg::IDX_W-1:0]         slot_index,
  output logic                              fresh_entry,
  output logic                              entry_committed,
  output logic [iws_pkg::N_W-1:0]           lowest_uncommitted,
  output logic [iws_pkg::N_W-1:0]           next_after_touched
);
  import iws_pkg::*;

  back_state_t state, state_next;

  slot_word_t  slot_mem [RING_SLOTS];
  slot_word_t  rd_word;
  logic              mem_re;
  logic [SLOT_W-1:0] mem_ra;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_wa;
  slot_word_t        mem_wd;

  logic [SLOT_W-1:0] clr_cnt, clr_cnt_next;

  logic           born, born_next;
  logic [N_W-1:0] birth_pt, birth_next;
  logic [N_W-1:0] begin_pt, begin_next;
  logic [N_W-1:0] wall_pt, wall_next;
  logic [N_W-1:0] snap_pt, snap_next;
  logic [N_W-1:0] uncm_pt, uncm_next;
  logic [N_W-1:0] touch_pt, touch_next;
  logic           cm_match, cm_match_next;
  logic           cm_comm, cm_comm_next;

  logic                fire;
  logic [STATUS_W-1:0] res_status;
  logic [SLOT_W-1:0]   res_slot;
  logic                res_fresh;
  logic                res_comm;

  logic [N_W-1:0]      n;
  logic                out_free;
  logic [N_W:0]        lim_begin;
  logic [STATUS_W-1:0] lk_status;
  logic                lk_slide;
  logic [N_W-1:0]      lk_begin;
  logic [N_W-1:0]      lk_uncm;
  logic                lk_stale;
  logic                cm_hit;
  logic                wk_more;
  logic                wk_stale;
  logic                wk_cont;
  logic [N_W-1:0]      lk_inc;
  logic [N_W-1:0]      wk_inc;
  logic                clr_last;

  assign n         = head.n;
  assign out_free  = !out_valid || out_ready;
  assign lim_begin = {1'b0, begin_pt} + SPAN;
  assign clearing  = (state == BK_CLEAR);
  assign clr_last  = (clr_cnt == SLOT_W'(RING_SLOTS - 1));

  always_comb begin
    if (!born || n < birth_pt) begin
      lk_status = STATUS_DEAD;
    end else if (n < begin_pt) begin
      lk_status = STATUS_FORGOTTEN;
    end else if (n >= wall_pt) begin
      lk_status = STATUS_BEHIND_WALL;
    end else if ({1'b0, n} >= {1'b0, snap_pt} + SPAN) begin
      lk_status = STATUS_UNREACHABLE;
    end else begin
      lk_status = STATUS_OK;
    end
  end

  // Slide the window so that the looked-up instance is its last slot.
  assign lk_slide = ({1'b0, n} >= lim_begin);
  assign lk_begin = lk_slide ? n - SPAN_M1 : begin_pt;
  assign lk_uncm  = (uncm_pt < lk_begin) ? lk_begin : uncm_pt;
  assign lk_stale = !rd_word.valid || (rd_word.tag != n);
  assign lk_inc   = inc_sat(n);

  assign cm_hit   = rd_word.valid && (rd_word.tag == n);

  assign wk_more  = ({1'b0, uncm_pt} < lim_begin);
  assign wk_stale = !rd_word.valid || (rd_word.tag != uncm_pt);
  assign wk_cont  = !wk_stale && rd_word.committed && (uncm_pt != '1);
  assign wk_inc   = inc_sat(uncm_pt);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      BK_CLEAR: begin
        if (clr_last) begin
          state_next = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (head_valid) begin
          case (head.op)
            OP_LOOKUP: begin
              if (lk_status == STATUS_OK) begin
                state_next = BK_LK_CHK;
              end
            end
            OP_COMMIT: begin
              if (born) begin
                state_next = BK_CM_CHK;
              end
            end
            default: state_next = BK_IDLE;
          endcase
        end
      end
      BK_LK_CHK: begin
        if (out_free) begin
          state_next = BK_IDLE;
        end
      end
      BK_CM_CHK: state_next = BK_WK_RD;
      BK_WK_RD: begin
        if (wk_more) begin
          state_next = BK_WK_CHK;
        end else if (out_free) begin
          state_next = BK_IDLE;
        end
      end
      BK_WK_CHK: begin
        if (wk_cont) begin
          state_next = BK_WK_RD;
        end else if (out_free) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // Datapath control
  always_comb begin
    mem_re        = 1'b0;
    mem_ra        = slot_of(n);
    mem_we        = 1'b0;
    mem_wa        = clr_cnt;
    mem_wd        = '0;
    clr_cnt_next  = clr_cnt;
    fire          = 1'b0;
    pop           = 1'b0;
    res_status    = STATUS_OK;
    res_slot      = '0;
    res_fresh     = 1'b0;
    res_comm      = 1'b0;
    born_next     = born;
    birth_next    = birth_pt;
    begin_next    = begin_pt;
    wall_next     = wall_pt;
    snap_next     = snap_pt;
    uncm_next     = uncm_pt;
    touch_next    = touch_pt;
    cm_match_next = cm_match;
    cm_comm_next  = cm_comm;

    case (state)
      BK_CLEAR: begin
        mem_we       = 1'b1;
        clr_cnt_next = clr_cnt + SLOT_W'(1);
      end
      BK_IDLE: begin
        if (head_valid) begin
          case (head.op)
            OP_LOOKUP: begin
              if (lk_status == STATUS_OK) begin
                mem_re = 1'b1;
              end else if (out_free) begin
                fire       = 1'b1;
                pop        = 1'b1;
                res_status = lk_status;
              end
            end
            OP_COMMIT: begin
              if (born) begin
                mem_re = 1'b1;
              end else if (out_free) begin
                fire       = 1'b1;
                pop        = 1'b1;
                res_status = STATUS_DEAD;
              end
            end
            OP_BIRTH: begin
              if (out_free) begin
                fire       = 1'b1;
                pop        = 1'b1;
                born_next  = 1'b1;
                birth_next = n;
                begin_next = n;
                wall_next  = n;
                snap_next  = n;
                uncm_next  = n;
                touch_next = n;
              end
            end
            OP_WALL: begin
              if (out_free) begin
                fire = 1'b1;
                pop  = 1'b1;
                if (n > wall_pt) begin
                  wall_next = n;
                end
              end
            end
            OP_SNAP: begin
              if (out_free) begin
                fire = 1'b1;
                pop  = 1'b1;
                if (n > snap_pt) begin
                  snap_next = n;
                end
              end
            end
            default: begin
              if (out_free) begin
                fire = 1'b1;
                pop  = 1'b1;
              end
            end
          endcase
        end
      end
      BK_LK_CHK: begin
        if (out_free) begin
          fire       = 1'b1;
          pop        = 1'b1;
          begin_next = lk_begin;
          uncm_next  = lk_uncm;
          if (lk_inc > touch_pt) begin
            touch_next = lk_inc;
          end
          if (lk_stale) begin
            mem_we = 1'b1;
            mem_wa = slot_of(n);
            mem_wd = '{valid: 1'b1, committed: 1'b0, tag: n};
          end
          res_slot  = slot_of(n);
          res_fresh = lk_stale;
          res_comm  = !lk_stale && rd_word.committed;
        end
      end
      BK_CM_CHK: begin
        cm_match_next = cm_hit;
        cm_comm_next  = cm_hit || rd_word.committed;
        if (cm_hit) begin
          mem_we = 1'b1;
          mem_wa = slot_of(n);
          mem_wd = '{valid: 1'b1, committed: 1'b1, tag: n};
        end
      end
      BK_WK_RD: begin
        mem_ra = slot_of(uncm_pt);
        if (wk_more) begin
          mem_re = 1'b1;
        end else if (out_free) begin
          fire       = 1'b1;
          pop        = 1'b1;
          res_status = cm_match ? STATUS_OK : STATUS_UNREACHABLE;
          res_slot   = slot_of(n);
          res_comm   = cm_comm;
        end
      end
      BK_WK_CHK: begin
        // Advance over a committed slot, or stop here and report.
        if (wk_cont || out_free) begin
          if (wk_inc > touch_pt) begin
            touch_next = wk_inc;
          end
          if (wk_stale) begin
            mem_we = 1'b1;
            mem_wa = slot_of(uncm_pt);
            mem_wd = '{valid: 1'b1, committed: 1'b0, tag: uncm_pt};
            if (slot_of(uncm_pt) == slot_of(n)) begin
              cm_comm_next = 1'b0;
            end
          end
          if (wk_cont) begin
            uncm_next = uncm_pt + N_W'(1);
          end else begin
            fire       = 1'b1;
            pop        = 1'b1;
            res_status = cm_match ? STATUS_OK : STATUS_UNREACHABLE;
            res_slot   = slot_of(n);
            res_comm   = cm_comm_next;
          end
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_word <= slot_mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_CLEAR;
      clr_cnt   <= '0;
      born      <= 1'b0;
      birth_pt  <= '0;
      begin_pt  <= '0;
      wall_pt   <= '0;
      snap_pt   <= '0;
      uncm_pt   <= '0;
      touch_pt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_cnt   <= clr_cnt_next;
      born      <= born_next;
      birth_pt  <= birth_next;
      begin_pt  <= begin_next;
      wall_pt   <= wall_next;
      snap_pt   <= snap_next;
      uncm_pt   <= uncm_next;
      touch_pt  <= touch_next;
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cm_match <= cm_match_next;
    cm_comm  <= cm_comm_next;
    if (fire) begin
      status             <= res_status;
      slot_index         <= IDX_W'(res_slot);
      fresh_entry        <= res_fresh;
      entry_committed    <= res_comm;
      lowest_uncommitted <= uncm_next;
      next_after_touched <= touch_next;
    end
  end

endmodule

`default_nettype wire

[dv/instance_window_store_tb.sv]
// Self-checking testbench for the instance window store: directed table, then random windows.
`timescale 1ns / 1ps

module instance_window_store_tb;
  import iws_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned PHASE_ITEMS = 210;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    slot;
    logic                fresh;
    logic                committed;
    logic [N_W-1:0]      low_open;
    logic [N_W-1:0]      touched_end;
  } window_result_t;

  typedef struct packed {
    logic [KIND_W-1:0]   op;
    logic [N_W-1:0]      n;
    logic                typed;
    logic [STATUS_W-1:0] status;
    logic [N_W-1:0]      low_open;
    logic [N_W-1:0]      touched_end;
  } script_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [KIND_W-1:0]   kind = '0;
  logic [N_W-1:0]      instance_number = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [IDX_W-1:0]    slot_index;
  logic                fresh_entry;
  logic                entry_committed;
  logic [N_W-1:0]      lowest_uncommitted;
  logic [N_W-1:0]      next_after_touched;

  instance_window_store dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .kind               (kind),
    .instance_number    (instance_number),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .status             (status),
    .slot_index         (slot_index),
    .fresh_entry        (fresh_entry),
    .entry_committed    (entry_committed),
    .lowest_uncommitted (lowest_uncommitted),
    .next_after_touched (next_after_touched)
  );

  // Window model state
  logic [N_W-1:0] tag_of_slot [RING_SLOTS];
  bit             slot_live   [RING_SLOTS];
  bit             slot_done   [RING_SLOTS];
  bit             is_born;
  logic [N_W-1:0] birth_at = '0;
  logic [N_W-1:0] begin_at = '0;
  logic [N_W-1:0] wall_at = '0;
  logic [N_W-1:0] snap_at = '0;
  logic [N_W-1:0] low_open = '0;
  logic [N_W-1:0] touched_end = '0;

  window_result_t expected_results [$];
  script_row_t    directed_rows [$];
  int unsigned    offered_items;
  int unsigned    checked_items;
  int unsigned    fail_count;
  int unsigned    send_idle_pct;
  int unsigned    recv_idle_pct;
  bit             hold_request;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  initial begin
    #20_000_000;
    $display("instance_window_store_tb: FAIL");
    $finish;
  end

  // Re-initialise a stale slot and raise the touched mark; return 1 if fresh.
  function automatic bit refresh_slot(logic [N_W-1:0] n);
    int unsigned s;
    bit fresh;
    s = n % RING_SLOTS;
    fresh = 1'b0;
    if (!slot_live[s] || tag_of_slot[s] != n) begin
      tag_of_slot[s] = n;
      slot_live[s] = 1'b1;
      slot_done[s] = 1'b0;
      fresh = 1'b1;
    end
    if (((n == '1) ? n : n + 1'b1) > touched_end) touched_end = (n == '1) ? n : n + 1'b1;
    return fresh;
  endfunction

  function automatic void walk_low_open();
    while ({1'b0, low_open} < {1'b0, begin_at} + 33'(RING_SLOTS)) begin
      void'(refresh_slot(low_open));
      if (!slot_done[low_open % RING_SLOTS] || low_open == '1) break;
      low_open = low_open + 1'b1;
    end
  endfunction

  function automatic window_result_t apply_request(logic [KIND_W-1:0] op, logic [N_W-1:0] n);
    window_result_t r;
    int unsigned s;
    r = '0;
    s = n % RING_SLOTS;
    case (op)
      KIND_LOOKUP: begin
        if (!is_born || n < birth_at) begin
          r.status = STATUS_DEAD;
        end else if (n < begin_at) begin
          r.status = STATUS_FORGOTTEN;
        end else if (n >= wall_at) begin
          r.status = STATUS_BEHIND_WALL;
        end else if ({1'b0, n} >= {1'b0, snap_at} + 33'(RING_SLOTS)) begin
          r.status = STATUS_UNREACHABLE;
        end else begin
          // slide the window so that n is its last slot
          if ({1'b0, n} >= {1'b0, begin_at} + 33'(RING_SLOTS)) begin
            begin_at = n - N_W'(RING_SLOTS - 1);
            if (low_open < begin_at) low_open = begin_at;
          end
          r.fresh = refresh_slot(n);
          r.slot = IDX_W'(s);
          r.committed = slot_done[s];
        end
      end
      KIND_BIRTH: begin
        is_born = 1'b1;
        birth_at = n;
        begin_at = n;
        wall_at = n;
        snap_at = n;
        low_open = n;
        touched_end = n;
      end
      KIND_WALL: if (n > wall_at) wall_at = n;
      KIND_SNAP: if (n > snap_at) snap_at = n;
      KIND_COMMIT: begin
        if (!is_born) begin
          r.status = STATUS_DEAD;
        end else begin
          if (slot_live[s] && tag_of_slot[s] == n) slot_done[s] = 1'b1;
          else r.status = STATUS_UNREACHABLE;
          walk_low_open();
          r.slot = IDX_W'(s);
          r.committed = slot_done[s];
        end
      end
      default: ;
    endcase
    r.low_open = low_open;
    r.touched_end = touched_end;
    return r;
  endfunction

  function automatic logic [N_W-1:0] sat_add(logic [N_W-1:0] a, int unsigned d);
    logic [N_W:0] sum;
    sum = {1'b0, a} + (N_W + 1)'(d);
    return sum[N_W] ? '1 : sum[N_W-1:0];
  endfunction

  function automatic void script_row(logic [KIND_W-1:0] op, logic [N_W-1:0] n, logic typed,
                                     logic [STATUS_W-1:0] st, logic [N_W-1:0] low,
                                     logic [N_W-1:0] touched);
    directed_rows.push_back({op, n, typed, st, low, touched});
  endfunction

  task automatic report_mismatch(string what, logic [N_W-1:0] got, logic [N_W-1:0] want);
    if (fail_count < 100)
      $display("%0t item %0d: %s got %h expected %h", $time, checked_items, what, got, want);
    fail_count++;
  endtask

  // Offer one item, hold it until taken, then log its expected result.
  task automatic send_item(logic [KIND_W-1:0] op, logic [N_W-1:0] n, bit typed,
                           window_result_t want);
    window_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    kind <= op;
    instance_number <= n;
    do @(posedge clk); while (!in_ready);
    predicted = apply_request(op, n);
    expected_results.push_back(typed ? want : predicted);
    offered_items++;
    @(negedge clk);
  endtask

  task automatic offer(logic [KIND_W-1:0] op, logic [N_W-1:0] n);
    send_item(op, n, 1'b0, '0);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // One birth, wall and snapshot, then a random mix of lookups, commits, wall and snapshot moves and other kinds.
  task automatic run_window_sequence();
    logic [N_W-1:0] base;
    logic [N_W-1:0] front;
    logic [N_W-1:0] n;
    logic [N_W-1:0] seen [$];
    int unsigned pick;
    int unsigned steps;
    int unsigned at;
    pick = $urandom_range(9);
    if (pick < 5) base = $urandom;
    else if (pick < 8) base = $urandom_range(3000);
    else base = 32'hFFFF_FFFF - $urandom_range(2500);
    offer(KIND_BIRTH, base);
    offer(KIND_WALL, ($urandom_range(9) == 0) ? '1 : sat_add(base, $urandom_range(1, 2600)));
    offer(KIND_SNAP, sat_add(base, $urandom_range(0, 1800)));
    front = base;
    steps = $urandom_range(20, 60);
    repeat (steps) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        if (pick < 32) begin
          n = front;
          front = sat_add(front, $urandom_range(0, 2));
        end else if (pick < 36) begin
          n = base - $urandom_range(1, 3);
        end else begin
          n = sat_add(base, $urandom_range(0, 3000));
        end
        offer(KIND_LOOKUP, n);
        seen.push_back(n);
      end else if (pick < 75) begin
        if (pick < 60 && seen.size() != 0) begin
          at = $urandom_range(seen.size() - 1);
          n = seen[at];
          seen.delete(at);
        end else if (pick < 70) begin
          n = low_open;
        end else begin
          n = sat_add(base, $urandom_range(0, 2000));
        end
        offer(KIND_COMMIT, n);
      end else if (pick < 82) begin
        offer(KIND_WALL, sat_add(wall_at, $urandom_range(0, 600)));
      end else if (pick < 89) begin
        offer(KIND_SNAP, sat_add(snap_at, $urandom_range(0, 600)));
      end else if (pick < 95) begin
        offer(KIND_W'($urandom_range(7)), $urandom);
      end else begin
        offer(KIND_W'($urandom_range(7)), sat_add(base, $urandom_range(0, 4000)));
      end
    end
  endtask

  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : check_results
    window_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, status", N_W'(status), '0);
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status) report_mismatch("status", N_W'(status), N_W'(want.status));
        if (slot_index !== want.slot)
          report_mismatch("slot_index", N_W'(slot_index), N_W'(want.slot));
        if (fresh_entry !== want.fresh)
          report_mismatch("fresh_entry", N_W'(fresh_entry), N_W'(want.fresh));
        if (entry_committed !== want.committed)
          report_mismatch("entry_committed", N_W'(entry_committed), N_W'(want.committed));
        if (lowest_uncommitted !== want.low_open)
          report_mismatch("lowest_uncommitted", lowest_uncommitted, want.low_open);
        if (next_after_touched !== want.touched_end)
          report_mismatch("next_after_touched", next_after_touched, want.touched_end);
      end
      checked_items++;
    end
  end

  initial begin : stimulus
    window_result_t want;
    int unsigned phase_end;
    @(negedge clk);
    while (rst) @(negedge clk);
    send_idle_pct = 15;
    recv_idle_pct = 46;

    // op, instance, typed, status, lowest uncommitted, next after touched
    script_row(KIND_LOOKUP,   32'h0000_0000, 1, STATUS_DEAD,        32'h0,   32'h0);
    script_row(KIND_COMMIT,   32'hFFFF_FFFF, 1, STATUS_DEAD,        32'h0,   32'h0);
    script_row(KIND_WALL,     32'hFFFF_FFFF, 1, STATUS_OK,          32'h0,   32'h0);
    script_row(KIND_SNAP,     32'hAAAA_AAAA, 1, STATUS_OK,          32'h0,   32'h0);
    script_row(KIND_SPARE_LO, 32'h5555_5555, 1, STATUS_OK,          32'h0,   32'h0);
    script_row(KIND_SPARE_HI, 32'hFFFF_FFFF, 1, STATUS_OK,          32'h0,   32'h0);
    script_row(KIND_BIRTH,    32'h0000_0100, 1, STATUS_OK,          32'h100, 32'h100);
    script_row(KIND_LOOKUP,   32'h0000_00FF, 1, STATUS_DEAD,        32'h100, 32'h100);
    script_row(KIND_LOOKUP,   32'h0000_0100, 1, STATUS_BEHIND_WALL, 32'h100, 32'h100);
    script_row(KIND_WALL,     32'h0000_0900, 1, STATUS_OK,          32'h100, 32'h100);
    script_row(KIND_LOOKUP,   32'h0000_0500, 1, STATUS_UNREACHABLE, 32'h100, 32'h100);
    script_row(KIND_LOOKUP,   32'h0000_0100, 0, STATUS_OK,          '0,      '0);
    script_row(KIND_LOOKUP,   32'h0000_0100, 0, STATUS_OK,          '0,      '0);
    script_row(KIND_COMMIT,   32'h0000_0100, 0, STATUS_OK,          '0,      '0);
    script_row(KIND_SNAP,     32'h0000_0600, 0, STATUS_OK,          '0,      '0);
    script_row(KIND_LOOKUP,   32'h0000_0600, 0, STATUS_OK,          '0,      '0);
    script_row(KIND_LOOKUP,   32'h0000_0150, 0, STATUS_OK,          '0,      '0);
    script_row(KIND_COMMIT,   32'h0000_0203, 0, STATUS_OK,          '0,      '0);
    script_row(KIND_COMMIT,   32'h0000_0201, 0, STATUS_OK,          '0,      '0);
    script_row(KIND_BIRTH,    32'hFFFF_FFFE, 1, STATUS_OK,          32'hFFFF_FFFE, 32'hFFFF_FFFE);
    script_row(KIND_WALL,     32'hFFFF_FFFF, 0, STATUS_OK,          '0,      '0);
    script_row(KIND_LOOKUP,   32'hFFFF_FFFE, 0, STATUS_OK,          '0,      '0);
    script_row(KIND_COMMIT,   32'hFFFF_FFFE, 0, STATUS_OK,          '0,      '0);
    script_row(KIND_COMMIT,   32'hFFFF_FFFF, 0, STATUS_OK,          '0,      '0);
    script_row(KIND_LOOKUP,   32'hFFFF_FFFF, 0, STATUS_OK,          '0,      '0);

    foreach (directed_rows[i]) begin
      want = '0;
      want.status = directed_rows[i].status;
      want.low_open = directed_rows[i].low_open;
      want.touched_end = directed_rows[i].touched_end;
      send_item(directed_rows[i].op, directed_rows[i].n, directed_rows[i].typed, want);
    end
    drain_results();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 46 : 0;
      recv_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 15 : 0;
      // stall the receiver for a long stretch so the input backs up
      if (phase == 2) hold_request = 1'b1;
      phase_end = offered_items + PHASE_ITEMS;
      while (offered_items < phase_end) run_window_sequence();
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("instance_window_store_tb: PASS");
    end else begin
      $display("instance_window_store_tb: FAIL");
    end
    $finish;
  end

endmodule
